// ----- rtl/ncbl_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ncbl_pkg
// Shared types, widths and codes for the nearest centre bin lookup unit.
// ----------------------------------------------------------------------------
package ncbl_pkg;

  // Field widths
  localparam int LEVEL_W    = 16;
  localparam int NBINS_W    = 13;
  localparam int NCENT_W    = 5;
  localparam int SLOT_W     = 4;
  localparam int BIN_W      = 12;
  localparam int PROD_W     = BIN_W + LEVEL_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Default table depth
  localparam int DEFAULT_MAX_CENTRES = 16;

  // Bin count limits
  localparam logic [NBINS_W-1:0] NBINS_MIN = 13'd2;
  localparam logic [NBINS_W-1:0] NBINS_MAX = 13'd4096;

  // Register reset values
  localparam logic [LEVEL_W-1:0] MAX_LEVEL_RST   = 16'hFFFF;
  localparam logic [NBINS_W-1:0] NUM_BINS_RST    = 13'd256;
  localparam logic [NCENT_W-1:0] NUM_CENTRES_RST = 5'd16;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEVEL   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_BINS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_CENTRES = 2'd2;

  // Request codes
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // Control sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_SCAN,
    S_DONE
  } state_t;

  // Divider status
  typedef struct packed {
    logic                 done;
    logic [LEVEL_W-1:0]   quot;
  } div_status_t;

endpackage

// ----- rtl/ncbl_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ncbl_if
// Valid/ready channels of the lookup unit: requests, results, register writes.
// ----------------------------------------------------------------------------

// Request channel
interface ncbl_req_if import ncbl_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               req_type;
  logic [SLOT_W-1:0]  centre_slot;
  logic [LEVEL_W-1:0] centre_level;
  logic [BIN_W-1:0]   bin_index;

  modport source (output valid, req_type, centre_slot, centre_level, bin_index,
                  input ready);
  modport sink   (input valid, req_type, centre_slot, centre_level, bin_index,
                  output ready);
endinterface

// Result channel
interface ncbl_res_if import ncbl_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [SLOT_W-1:0]  nearest_centre;
  logic [LEVEL_W-1:0] bin_level;

  modport source (output valid, nearest_centre, bin_level, input ready);
  modport sink   (input valid, nearest_centre, bin_level, output ready);
endinterface

// Register write channel
interface ncbl_cfg_if import ncbl_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/nearest_centre_bin_lookup_unit.sv -----
`timescale 1ns / 1ps
// Query: after a query transfers, the bit-serial divider computes the bin level,
//   then the scan does one centre table read per cycle; the result is registered.
// Requests are accepted only in the idle state, so a new query or load waits until
//   the previous query's result is loaded; a load writes the table on its transfer.
// Reset: registers return to max_level 65535, num_bins 256, num_centres 16;
//   the centre table is not cleared and holds garbage until loaded.
// ----------------------------------------------------------------------------
// nearest_centre_bin_lookup_unit
// Maps a bin index to its level and finds the nearest stored centre level.
// ----------------------------------------------------------------------------
module nearest_centre_bin_lookup_unit import ncbl_pkg::*; #(
  parameter int MAX_CENTRES = DEFAULT_MAX_CENTRES
) (
  input  logic        clk,
  input  logic        rst,
  ncbl_req_if.sink    req,
  ncbl_res_if.source  res,
  ncbl_cfg_if.sink    cfg
);

  localparam int IW = (MAX_CENTRES > 1) ? $clog2(MAX_CENTRES) : 1;
  localparam int CW = $clog2(MAX_CENTRES + 1);

  state_t state, state_next;

  // Configuration registers
  logic [LEVEL_W-1:0] max_level;
  logic [NBINS_W-1:0] num_bins;
  logic [NCENT_W-1:0] num_centres;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_level   <= MAX_LEVEL_RST;
      num_bins    <= NUM_BINS_RST;
      num_centres <= NUM_CENTRES_RST;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        CFG_MAX_LEVEL:   max_level   <= cfg.data[LEVEL_W-1:0];
        CFG_NUM_BINS:    num_bins    <= cfg.data[NBINS_W-1:0];
        CFG_NUM_CENTRES: num_centres <= cfg.data[NCENT_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective bin count, clamped bin, product
  logic [NBINS_W-1:0] nb_eff;
  logic [BIN_W-1:0]   nb_m1;
  logic [BIN_W-1:0]   bin_clamped;
  logic [PROD_W-1:0]  product;

  always_comb begin
    if (num_bins < NBINS_MIN)      nb_eff = NBINS_MIN;
    else if (num_bins > NBINS_MAX) nb_eff = NBINS_MAX;
    else                           nb_eff = num_bins;
    nb_m1       = BIN_W'(nb_eff - 1'b1);
    bin_clamped = (req.bin_index > nb_m1) ? nb_m1 : req.bin_index;
    product     = PROD_W'(bin_clamped) * PROD_W'(max_level);
  end

  // Effective centre count
  logic [31:0]   nc_wide;
  logic [CW-1:0] nc_eff;

  always_comb begin
    if (num_centres == '0)                     nc_wide = 32'd1;
    else if (32'(num_centres) > MAX_CENTRES)   nc_wide = 32'(MAX_CENTRES);
    else                                       nc_wide = 32'(num_centres);
    nc_eff = nc_wide[CW-1:0];
  end

  logic req_xfer;
  logic is_query;
  assign req_xfer = req.valid && req.ready;
  assign is_query = req_xfer && (req.req_type == REQ_QUERY);

  // Divider
  div_status_t div_st;

  ncbl_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (is_query),
    .dividend (product),
    .divisor  (nb_m1),
    .status   (div_st)
  );

  // Centre table
  logic [LEVEL_W-1:0] centre_mem [MAX_CENTRES];
  logic [LEVEL_W-1:0] mem_q;
  logic [31:0]        slot_wide;
  logic               slot_ok;
  logic [CW-1:0]      issue_cnt;
  logic               rd_issue;

  assign slot_wide = 32'(req.centre_slot);
  assign slot_ok   = (slot_wide < 32'(MAX_CENTRES));
  assign rd_issue  = (state == S_SCAN) && (issue_cnt < nc_eff);

  always_ff @(posedge clk) begin
    if (req_xfer && (req.req_type == REQ_LOAD) && slot_ok) begin
      centre_mem[slot_wide[IW-1:0]] <= req.centre_level;
    end
    if (rd_issue) begin
      mem_q <= centre_mem[issue_cnt[IW-1:0]];
    end
  end

  // Scan bookkeeping and running minimum
  logic               rd_valid;
  logic [IW-1:0]      rd_idx;
  logic [LEVEL_W-1:0] level;
  logic [LEVEL_W-1:0] best_diff;
  logic [IW-1:0]      best_idx;
  logic [LEVEL_W-1:0] delta;
  logic               take;
  logic               scan_end;

  always_comb begin
    delta    = (mem_q >= level) ? (mem_q - level) : (level - mem_q);
    take     = rd_valid && ((rd_idx == '0) || (delta < best_diff));
    scan_end = (issue_cnt == nc_eff) && !rd_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid  <= 1'b0;
      issue_cnt <= '0;
    end else begin
      rd_valid <= rd_issue;
      if (state == S_DIV) begin
        issue_cnt <= '0;
      end else if (rd_issue) begin
        issue_cnt <= issue_cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (div_st.done) level <= div_st.quot;
    if (rd_issue)    rd_idx <= issue_cnt[IW-1:0];
    if (take) begin
      best_diff <= delta;
      best_idx  <= rd_idx;
    end
  end

  // Output register
  logic               res_valid;
  logic [SLOT_W-1:0]  res_centre;
  logic [LEVEL_W-1:0] res_level;
  logic               res_load;
  logic [31:0]        best_wide;

  assign best_wide = 32'(best_idx);
  assign res_load  = (state == S_DONE) && (!res_valid || res.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_centre <= best_wide[SLOT_W-1:0];
      res_level  <= level;
    end
  end

  assign res.valid          = res_valid;
  assign res.nearest_centre = res_centre;
  assign res.bin_level      = res_level;

  // Sequencer: next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (is_query)    state_next = S_DIV;
      S_DIV:   if (div_st.done) state_next = S_SCAN;
      S_SCAN:  if (scan_end)    state_next = S_DONE;
      S_DONE:  if (res_load)    state_next = S_IDLE;
      default:                  state_next = S_IDLE;
    endcase
  end

  // Sequencer: outputs
  always_comb begin
    case (state)
      S_IDLE:  req.ready = 1'b1;
      default: req.ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // Checks
  a_rise_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(res.valid) |-> $past(state == S_DONE))
    else $error("result raised outside the done state");

  a_div_in_div: assert property (@(posedge clk) disable iff (rst)
    div_st.done |-> (state == S_DIV))
    else $error("divider finished outside the divide state");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (issue_cnt <= nc_eff))
    else $error("scan ran past the centre count");

  a_query_starts_div: assert property (@(posedge clk) disable iff (rst)
    is_query |=> (state == S_DIV))
    else $error("query transfer did not start the divide");

endmodule

// ----- rtl/ncbl_divider.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ncbl_divider
// Restoring divider, one quotient bit per cycle, for the bin level.
// ----------------------------------------------------------------------------
module ncbl_divider import ncbl_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [PROD_W-1:0] dividend,
  input  logic [BIN_W-1:0]  divisor,
  output div_status_t       status
);

  localparam int CNT_W = $clog2(PROD_W + 1);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(PROD_W - 1);

  logic              busy;
  logic              done;
  logic [CNT_W-1:0]  cnt;
  logic [BIN_W-1:0]  rem;
  logic [BIN_W-1:0]  dvsr;
  logic [PROD_W-1:0] quo;

  logic [BIN_W:0]    trial;
  logic [BIN_W:0]    diff;
  logic              qbit;

  // Trial subtract of the shifted remainder
  always_comb begin
    trial = {rem, quo[PROD_W-1]};
    diff  = trial - {1'b0, dvsr};
    qbit  = (trial >= {1'b0, dvsr});
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: dividend shifts out as quotient shifts in
  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      dvsr <= divisor;
      quo  <= dividend;
    end else if (busy) begin
      rem <= qbit ? diff[BIN_W-1:0] : trial[BIN_W-1:0];
      quo <= {quo[PROD_W-2:0], qbit};
    end
  end

  assign status.done = done;
  assign status.quot = quo[LEVEL_W-1:0];

endmodule
